// ===== design/laplacian_five_point_stencil_assert.svh =====
// Assertion macros for the five-point Laplacian stencil checker.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef LAPLACIAN_FIVE_POINT_STENCIL_ASSERT_SVH
`define LAPLACIAN_FIVE_POINT_STENCIL_ASSERT_SVH

// Property checked out of reset.
`define LFPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked also while reset is held.
`define LFPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/lfps_pkg.sv =====
// Shared types and constants of the five-point Laplacian stencil.
// No dependencies.
`default_nettype none

package lfps_pkg;

  // Configuration port
  localparam int unsigned CfgW    = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned SizeW   = 11;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRows       = 2'd0,
    CfgCols       = 2'd1,
    CfgInvSpacing = 2'd2
  } cfg_idx_e;

  localparam logic [SizeW-1:0] SizeMin      = SizeW'(3);
  localparam logic [SizeW-1:0] RowsReset    = SizeW'(1024);
  localparam logic [SizeW-1:0] ColsReset    = SizeW'(1024);
  localparam logic [CfgW-1:0]  InvSpReset   = CfgW'(256);

  // Grid size defaults
  localparam int unsigned MaxColsDef = 1024;
  localparam int unsigned MaxRowsDef = 1024;

  // Field widths
  localparam int unsigned SampleW = 24;
  localparam int unsigned LapW    = 48;
  localparam int unsigned CellW   = 10;
  // Column positions in the queue; covers column counts up to 4096
  localparam int unsigned PosW    = 12;

  // Arithmetic widths: stencil sum, product with the Q24.8 scale, shifted
  localparam int unsigned SumW    = SampleW + 3;
  localparam int unsigned ProdW   = SumW + CfgW + 1;
  localparam int unsigned FracSh  = 8;
  localparam int unsigned QW      = ProdW - FracSh;

  // Queue between front and back
  localparam int unsigned QDepth  = 4;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic [PosW-1:0]           col;       // column of this word
    logic [PosW-1:0]           ncol;      // column of the next word
    logic                      emit;      // word completes an interior cell
    logic [CellW-1:0]          cell_row;
    logic [CellW-1:0]          cell_col;
    logic                      last;
  } lfps_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } lfps_qstat_t;

endpackage

`default_nettype wire

// ===== design/lfps_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module lfps_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, hold data while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/lfps_front.sv =====
// Front end of the stencil: configuration registers, grid position tracking
// and classification of each input word. Depends on lfps_pkg.
`default_nettype none

module lfps_front
  import lfps_pkg::*;
#(
  parameter int unsigned MaxRows = MaxRowsDef,
  parameter int unsigned MaxCols = MaxColsDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output      logic                      in_stall_o,
  input  wire logic signed [SampleW-1:0] sample_i,
  input  wire logic                      cfg_we_i,
  input  wire logic [CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [CfgW-1:0]           cfg_wdata_i,
  output      logic [CfgW-1:0]           inv_spacing_o,
  input  wire lfps_qstat_t               qstat_i,
  output      logic                      push_o,
  output      lfps_item_t                item_o
);

  localparam int unsigned CW = $clog2(MaxCols);
  localparam int unsigned RW = $clog2(MaxRows);

  logic [SizeW-1:0] rows_cfg_q, cols_cfg_q;
  logic [CfgW-1:0]  inv_q;
  logic [CW-1:0]    col_q;
  logic [RW-1:0]    row_q;
  logic [CW:0]      cols, c_cur, c_nxt;
  logic [RW:0]      rows, r_cur, r_nxt;
  logic             accept;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= RowsReset;
      cols_cfg_q <= ColsReset;
      inv_q      <= InvSpReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRows:       rows_cfg_q <= cfg_wdata_i[SizeW-1:0];
        CfgCols:       cols_cfg_q <= cfg_wdata_i[SizeW-1:0];
        CfgInvSpacing: inv_q      <= cfg_wdata_i;
        default:       ;
      endcase
    end
  end

  assign inv_spacing_o = inv_q;

  // Clamp the grid size into the supported range
  always_comb begin
    if (cols_cfg_q < SizeMin) begin
      cols = (CW+1)'(SizeMin);
    end else if (32'(cols_cfg_q) > 32'(MaxCols)) begin
      cols = (CW+1)'(MaxCols);
    end else begin
      cols = (CW+1)'(cols_cfg_q);
    end
    if (rows_cfg_q < SizeMin) begin
      rows = (RW+1)'(SizeMin);
    end else if (32'(rows_cfg_q) > 32'(MaxRows)) begin
      rows = (RW+1)'(MaxRows);
    end else begin
      rows = (RW+1)'(rows_cfg_q);
    end
  end

  // Position of this word, and of the next one
  always_comb begin
    c_cur = {1'b0, col_q};
    r_cur = {1'b0, row_q};
    if (c_cur >= cols) begin
      c_cur = '0;
      r_cur = r_cur + 1'b1;
    end
    if (r_cur >= rows) begin
      r_cur = '0;
    end
    c_nxt = c_cur + 1'b1;
    r_nxt = r_cur;
    if (c_nxt >= cols) begin
      c_nxt = '0;
      r_nxt = r_cur + 1'b1;
      if (r_nxt >= rows) begin
        r_nxt = '0;
      end
    end
  end

  // Accept while the queue has room
  assign in_stall_o = qstat_i.full;
  assign accept     = in_valid_i && !qstat_i.full;
  assign push_o     = accept;

  // Classify the word: a word below an interior cell completes that cell
  always_comb begin
    item_o.sample   = sample_i;
    item_o.col      = PosW'(c_cur[CW-1:0]);
    item_o.ncol     = PosW'(c_nxt[CW-1:0]);
    item_o.emit     = (r_cur >= (RW+1)'(2)) && (c_cur != '0) &&
                      (c_cur <= cols - (CW+1)'(2));
    item_o.cell_row = CellW'(r_cur - 1'b1);
    item_o.cell_col = CellW'(c_cur);
    item_o.last     = (r_cur == rows - 1'b1) && (c_cur == cols - (CW+1)'(2));
  end

  // Advance the grid position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= c_nxt[CW-1:0];
      row_q <= r_nxt[RW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== design/lfps_queue.sv =====
// Short word queue between the stencil front and back ends.
// Depends on lfps_pkg.
`default_nettype none

module lfps_queue
  import lfps_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire lfps_item_t  item_i,
  input  wire logic        pop_i,
  output      lfps_item_t  head_o,
  output      lfps_qstat_t qstat_o
);

  localparam int unsigned PW = $clog2(QDepth);
  localparam int unsigned NW = $clog2(QDepth + 1);

  lfps_item_t    slot_q [QDepth];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [NW-1:0] count_q;

  // Store pushed words
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (32'(wr_ptr_q) == QDepth - 1) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (32'(rd_ptr_q) == QDepth - 1) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: ;
      endcase
    end
  end

  assign head_o        = slot_q[rd_ptr_q];
  assign qstat_o.empty = (count_q == '0);
  assign qstat_o.full  = (32'(count_q) == QDepth);

endmodule

`default_nettype wire

// ===== design/lfps_back.sv =====
// Back end of the stencil: line buffer, stencil sum, scaling, saturation and
// the output register. Depends on lfps_pkg and lfps_ram.
`default_nettype none

module lfps_back
  import lfps_pkg::*;
#(
  parameter int unsigned MaxCols = MaxColsDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire lfps_item_t              head_i,
  input  wire lfps_qstat_t             qstat_i,
  output      logic                    pop_o,
  input  wire logic [CfgW-1:0]         inv_spacing_i,
  output      logic                    out_valid_o,
  input  wire logic                    out_stall_i,
  output      logic signed [LapW-1:0]  laplacian_o,
  output      logic [CellW-1:0]        cell_row_o,
  output      logic [CellW-1:0]        cell_col_o,
  output      logic                    clipped_o,
  output      logic                    frame_last_o
);

  localparam int unsigned AW = $clog2(MaxCols);
  localparam int unsigned WW = 2 * SampleW;

  logic                      adv, have, fetch;
  logic                      ram_re, ram_we;
  logic [AW-1:0]             ram_raddr;
  logic [WW-1:0]             ram_rdata, ram_wdata;

  // Read stage
  logic                      s1_vld_q, s1_load_q;
  logic [AW-1:0]             s1_raddr_q;
  lfps_item_t                s1_item_q;
  // Prefetched line buffer word for the current column: {older, newer}
  logic                      pf_vld_q;
  logic [AW-1:0]             pf_addr_q;
  logic [WW-1:0]             pf_word_q;
  logic signed [SampleW-1:0] left_q;
  logic signed [SampleW-1:0] up, center, right;
  logic signed [SumW-1:0]    sum;
  // Sum stage
  logic                      s2_vld_q;
  logic signed [SumW-1:0]    s2_sum_q;
  logic [CellW-1:0]          s2_row_q, s2_col_q;
  logic                      s2_last_q;
  // Product stage
  logic                      s3_vld_q;
  logic signed [ProdW-1:0]   s3_prod_q;
  logic [CellW-1:0]          s3_row_q, s3_col_q;
  logic                      s3_last_q;
  logic signed [ProdW-1:0]   prod;
  logic signed [CfgW:0]      inv_s;
  logic signed [QW-1:0]      q;
  logic                      ovf;
  logic signed [LapW-1:0]    sat;

  // The whole back end moves when the output register can take a word
  assign adv = !out_valid_o || !out_stall_i;

  // The word at the head needs its own column prefetched one stage ahead
  assign have  = s1_load_q ? (s1_raddr_q == head_i.col[AW-1:0])
                           : (pf_vld_q && (pf_addr_q == head_i.col[AW-1:0]));
  assign pop_o = adv && !qstat_i.empty && have;
  assign fetch = adv && !qstat_i.empty && !have;

  // Line buffer: read the next column on pop, the own column on a miss
  assign ram_re    = pop_o || fetch;
  assign ram_raddr = pop_o ? head_i.ncol[AW-1:0] : head_i.col[AW-1:0];
  assign ram_we    = adv && s1_vld_q;
  assign ram_wdata = {pf_word_q[SampleW-1:0], s1_item_q.sample};

  lfps_ram #(
    .Width (WW),
    .Depth (MaxCols)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_item_q.col[AW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Read stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_load_q <= 1'b0;
      pf_vld_q  <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= pop_o;
      s1_load_q <= ram_re;
      if (s1_load_q) begin
        pf_vld_q <= 1'b1;
      end
    end
  end

  // Read stage payload, prefetch capture and left neighbor
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_item_q  <= head_i;
      s1_raddr_q <= ram_raddr;
      if (s1_load_q) begin
        pf_word_q <= ram_rdata;
        pf_addr_q <= s1_raddr_q;
      end
      if (s1_vld_q) begin
        left_q <= pf_word_q[SampleW-1:0];
      end
    end
  end

  // Five-point sum: up + down + left + right - 4 * center
  assign up     = pf_word_q[WW-1:SampleW];
  assign center = pf_word_q[SampleW-1:0];
  assign right  = ram_rdata[SampleW-1:0];
  assign sum    = SumW'(up) + SumW'(left_q) + SumW'(right) + SumW'(s1_item_q.sample)
                - (SumW'(center) <<< 2);

  // Scale by the Q24.8 reciprocal of h squared
  assign inv_s = $signed({1'b0, inv_spacing_i});
  assign prod  = s2_sum_q * inv_s;

  // Drop the fraction bits (floor) and saturate to the output range
  assign q   = QW'(s3_prod_q >>> FracSh);
  assign ovf = !((&q[QW-1:LapW-1]) || !(|q[QW-1:LapW-1]));
  assign sat = q[QW-1] ? {1'b1, {(LapW-1){1'b0}}} : {1'b0, {(LapW-1){1'b1}}};

  // Valid bits of the arithmetic stages and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q    <= 1'b0;
      s3_vld_q    <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (adv) begin
      s2_vld_q    <= s1_vld_q && s1_item_q.emit;
      s3_vld_q    <= s2_vld_q;
      out_valid_o <= s3_vld_q;
    end
  end

  // Arithmetic stage and output payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_sum_q     <= sum;
      s2_row_q     <= s1_item_q.cell_row;
      s2_col_q     <= s1_item_q.cell_col;
      s2_last_q    <= s1_item_q.last;
      s3_prod_q    <= prod;
      s3_row_q     <= s2_row_q;
      s3_col_q     <= s2_col_q;
      s3_last_q    <= s2_last_q;
      laplacian_o  <= ovf ? sat : q[LapW-1:0];
      clipped_o    <= ovf;
      cell_row_o   <= s3_row_q;
      cell_col_o   <= s3_col_q;
      frame_last_o <= s3_last_q;
    end
  end

endmodule

`default_nettype wire

// ===== design/laplacian_five_point_stencil.sv =====
// Five-point Laplacian stencil over a ghosted grid streamed in raster order.
// It takes one sample word per cycle, sustained, across row and frame
// boundaries while the output is not stalled; a result word passes through
// the queue, the read, sum and product stages and the output register. The
// first sample after reset, or after a size change that moves the grid
// position, stalls the back end while the line buffer read for its column is
// issued; after that the prefetch of the next column keeps the single read
// port of the line buffer busy while words flow. The two line buffers share
// one RAM of MaxCols words of 48 bits; it needs no clearing pass. A four-word
// queue lets the input keep flowing while the output is stalled, until it fills.
// Write the size and scale registers only while idle.
// Depends on lfps_pkg, lfps_front, lfps_queue and lfps_back.
`default_nettype none

module laplacian_five_point_stencil
  import lfps_pkg::*;
#(
  parameter int unsigned MaxRows = MaxRowsDef,
  parameter int unsigned MaxCols = MaxColsDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output      logic                      in_stall_o,
  input  wire logic signed [SampleW-1:0] sample_i,
  output      logic                      out_valid_o,
  input  wire logic                      out_stall_i,
  output      logic signed [LapW-1:0]    laplacian_o,
  output      logic [CellW-1:0]          cell_row_o,
  output      logic [CellW-1:0]          cell_col_o,
  output      logic                      clipped_o,
  output      logic                      frame_last_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [CfgW-1:0]           cfg_wdata_i
);

  logic            push, pop;
  lfps_item_t      push_item, head_item;
  lfps_qstat_t     qstat;
  logic [CfgW-1:0] inv_spacing;

  // Accept and classify words
  lfps_front #(
    .MaxRows (MaxRows),
    .MaxCols (MaxCols)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .inv_spacing_o (inv_spacing),
    .qstat_i       (qstat),
    .push_o        (push),
    .item_o        (push_item)
  );

  // Decouple front and back
  lfps_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .head_o  (head_item),
    .qstat_o (qstat)
  );

  // Line buffer, arithmetic and output
  lfps_back #(
    .MaxCols (MaxCols)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_item),
    .qstat_i       (qstat),
    .pop_o         (pop),
    .inv_spacing_i (inv_spacing),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .laplacian_o   (laplacian_o),
    .cell_row_o    (cell_row_o),
    .cell_col_o    (cell_col_o),
    .clipped_o     (clipped_o),
    .frame_last_o  (frame_last_o)
  );

endmodule

`default_nettype wire

// ===== design/lfps_checker.sv =====
// Port-level checker for the stencil, bound to the top level.
// Depends on lfps_pkg and laplacian_five_point_stencil_assert.svh.
`default_nettype none
`include "laplacian_five_point_stencil_assert.svh"

module lfps_checker
  import lfps_pkg::*;
(
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      out_valid_o,
  input wire logic                      out_stall_i,
  input wire logic signed [LapW-1:0]    laplacian_o,
  input wire logic [CellW-1:0]          cell_row_o,
  input wire logic [CellW-1:0]          cell_col_o,
  input wire logic                      clipped_o,
  input wire logic                      frame_last_o
);

  localparam logic signed [LapW-1:0] LapMax = {1'b0, {(LapW-1){1'b1}}};
  localparam logic signed [LapW-1:0] LapMin = {1'b1, {(LapW-1){1'b0}}};

  property p_out_hold;
    out_valid_o && out_stall_i |=> out_valid_o && $stable(laplacian_o) &&
      $stable(cell_row_o) && $stable(cell_col_o) && $stable(clipped_o) &&
      $stable(frame_last_o);
  endproperty

  property p_clip_rail;
    out_valid_o && clipped_o |-> laplacian_o == LapMax || laplacian_o == LapMin;
  endproperty

  property p_interior;
    out_valid_o |-> cell_row_o != '0 && cell_col_o != '0;
  endproperty

  property p_rst_quiet;
    !rst_ni |=> !out_valid_o;
  endproperty

  // Hold a stalled result word
  `LFPS_ASSERT(a_out_hold, p_out_hold, "stalled result word changed")

  // A clipped result sits at one end of the range
  `LFPS_ASSERT(a_clip_rail, p_clip_rail, "clipped result not at a rail")

  // Results are interior cells only
  `LFPS_ASSERT(a_interior, p_interior, "result on the ghost border")

  // No result while reset is held
  `LFPS_ASSERT_ALWAYS(a_rst_quiet, p_rst_quiet, "result during reset")

endmodule

bind laplacian_five_point_stencil lfps_checker u_lfps_checker (.*);

`default_nettype wire

// ===== tb/tb_laplacian_five_point_stencil.sv =====
`timescale 1ns / 100ps
// Self-checking bench for laplacian_five_point_stencil: streams ghosted grids in raster
// order, predicts every interior-cell word and compares it with the block's output.
// Depends on lfps_pkg and the stencil RTL.

module tb_laplacian_five_point_stencil;
  import lfps_pkg::*;

  localparam int unsigned ResetCycles   = 6;
  localparam int unsigned SettleCycles  = 12;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned RandomItems   = 1150;
  localparam int unsigned DirectedItems = 18;
  localparam int unsigned MaxReports    = 50;

  // Register index that decodes to nothing
  localparam logic [CfgIdxW-1:0] CfgNoReg = 2'd3;

  localparam logic signed [SampleW-1:0] SampleMax = {1'b0, {(SampleW-1){1'b1}}};
  localparam logic signed [SampleW-1:0] SampleMin = {1'b1, {(SampleW-1){1'b0}}};
  localparam longint LapMax = (longint'(1) <<< (LapW - 1)) - 1;
  localparam longint LapMin = -LapMax - 1;

  typedef struct {
    logic signed [LapW-1:0] laplacian;
    logic [CellW-1:0]       cell_row;
    logic [CellW-1:0]       cell_col;
    logic                   clipped;
    logic                   frame_last;
  } cell_result_t;

  // DUT stimulus, all known from time zero
  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic signed [SampleW-1:0] sample_i    = '0;
  logic                      out_stall_i = 1'b0;
  logic                      cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]        cfg_idx_i   = '0;
  logic [CfgW-1:0]           cfg_wdata_i = '0;

  logic                      in_stall_o;
  logic                      out_valid_o;
  logic signed [LapW-1:0]    laplacian_o;
  logic [CellW-1:0]          cell_row_o;
  logic [CellW-1:0]          cell_col_o;
  logic                      clipped_o;
  logic                      frame_last_o;

  // Stencil predictor state
  logic signed [SampleW-1:0] line_older [MaxColsDef];
  logic signed [SampleW-1:0] line_newer [MaxColsDef];
  int unsigned               grid_row = 0;
  int unsigned               grid_col = 0;
  logic [SizeW-1:0]          rows_reg  = RowsReset;
  logic [SizeW-1:0]          cols_reg  = ColsReset;
  logic [CfgW-1:0]           scale_reg = InvSpReset;

  logic signed [SampleW-1:0] samples_pending [$];
  cell_result_t              cells_due [$];

  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned items_queued       = 0;
  int unsigned items_taken        = 0;
  int unsigned cells_checked      = 0;
  int unsigned cells_clipped      = 0;
  int unsigned frames_done        = 0;
  int unsigned settings_run       = 0;
  int unsigned mismatches         = 0;
  int unsigned quiet_cycles       = 0;

  laplacian_five_point_stencil dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .laplacian_o  (laplacian_o),
    .cell_row_o   (cell_row_o),
    .cell_col_o   (cell_col_o),
    .clipped_o    (clipped_o),
    .frame_last_o (frame_last_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_dim(input logic [SizeW-1:0] v, input int unsigned top);
    if (v < SizeMin) return SizeMin;
    if (v > top) return top;
    return v;
  endfunction

  // Advance the grid position by one sample and queue the cell word it completes
  task automatic apply_stencil(input logic signed [SampleW-1:0] s);
    int unsigned  rows;
    int unsigned  cols;
    int unsigned  r;
    int unsigned  c;
    longint       sum;
    longint       prod;
    longint       q;
    cell_result_t res;
    rows = clamp_dim(rows_reg, MaxRowsDef);
    cols = clamp_dim(cols_reg, MaxColsDef);
    r = grid_row;
    c = grid_col;
    // Position left beyond a shrunk size wraps to the next row or to row 0
    if (c >= cols) begin
      c = 0;
      r++;
    end
    if (r >= rows) r = 0;
    if (r >= 2 && c >= 1 && c + 2 <= cols) begin
      sum = longint'(line_older[c]) + longint'(line_older[c-1]) + longint'(line_newer[c+1])
          + longint'(s) - 4 * longint'(line_newer[c]);
      prod = sum * $signed({32'd0, scale_reg});
      // Arithmetic shift floors toward minus infinity
      q = prod >>> FracSh;
      res.clipped = 1'b0;
      if (q > LapMax) begin
        q = LapMax;
        res.clipped = 1'b1;
      end
      if (q < LapMin) begin
        q = LapMin;
        res.clipped = 1'b1;
      end
      res.laplacian  = q[LapW-1:0];
      res.cell_row   = CellW'(r - 1);
      res.cell_col   = CellW'(c);
      res.frame_last = (r == rows - 1 && c == cols - 2);
      cells_due.push_back(res);
    end
    line_older[c] = line_newer[c];
    line_newer[c] = s;
    c++;
    if (c >= cols) begin
      c = 0;
      r++;
      if (r >= rows) r = 0;
    end
    grid_row = r;
    grid_col = c;
  endtask

  // Sender: hold a stalled word, otherwise launch the next pending word or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      sample_i   <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        apply_stencil(sample_i);
        items_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (samples_pending.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          in_valid_i <= 1'b1;
          sample_i   <= samples_pending.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < receiver_stall_pct);
    end
  end

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      if (mismatches < MaxReports)
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Compare each accepted cell word with the oldest prediction
  always @(posedge clk_i) begin : cell_check
    cell_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (cells_due.size() == 0) begin
        if (mismatches < MaxReports)
          $display("%0t ns: unexpected word, expected none, got laplacian %0h at (%0d,%0d)",
                   $time, laplacian_o, cell_row_o, cell_col_o);
        mismatches++;
      end else begin
        want = cells_due.pop_front();
        check_field("laplacian", want.laplacian, laplacian_o);
        check_field("cell_row", want.cell_row, cell_row_o);
        check_field("cell_col", want.cell_col, cell_col_o);
        check_field("clipped", want.clipped, clipped_o);
        check_field("frame_last", want.frame_last, frame_last_o);
        cells_checked++;
        if (want.clipped) cells_clipped++;
        if (want.frame_last) frames_done++;
      end
    end
  end

  // Count cycles in which no word moves on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WatchdogLimit) @(posedge clk_i);
    $display("Timeout after %0d cycles without a word accepted", WatchdogLimit);
    $display("FAILURE");
    $finish;
  end

  task automatic queue_sample(input logic signed [SampleW-1:0] s);
    samples_pending.push_back(s);
    items_queued++;
  endtask

  function automatic logic signed [SampleW-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return SampleMax;
      1:       return SampleMin;
      2:       return SampleW'($urandom_range(0, 511) - 256);
      default: return SampleW'($urandom);
    endcase
  endfunction

  function automatic logic [CfgW-1:0] rand_scale();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return InvSpReset;
      3:       return CfgW'($urandom_range(1, 4096));
      default: return $urandom;
    endcase
  endfunction

  // Samples still missing before the grid position is back at a frame start
  function automatic int unsigned frame_remaining();
    int unsigned rows;
    int unsigned cols;
    int unsigned r;
    int unsigned c;
    rows = clamp_dim(rows_reg, MaxRowsDef);
    cols = clamp_dim(cols_reg, MaxColsDef);
    r = grid_row;
    c = grid_col;
    if (c >= cols) begin
      c = 0;
      r++;
    end
    if (r >= rows) r = 0;
    if (r == 0 && c == 0) return 0;
    return rows * cols - (r * cols + c);
  endfunction

  // Wait until every word is taken and every cell word has come, then let the pipe empty
  task automatic wait_drained();
    @(posedge clk_i);
    while (samples_pending.size() != 0 || in_valid_i || cells_due.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      CfgRows:       rows_reg  = value[SizeW-1:0];
      CfgCols:       cols_reg  = value[SizeW-1:0];
      CfgInvSpacing: scale_reg = value;
      default:       ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Complete the running frame, reprogram the grid, then stream whole frames
  task automatic run_setting(input logic [SizeW-1:0] rows_raw, input logic [SizeW-1:0] cols_raw,
                             input logic [CfgW-1:0] scale, input int unsigned frames);
    int unsigned n;
    wait_drained();
    n = frame_remaining();
    repeat (n) queue_sample(rand_sample());
    wait_drained();
    write_reg(CfgRows, CfgW'(rows_raw));
    write_reg(CfgCols, CfgW'(cols_raw));
    write_reg(CfgInvSpacing, scale);
    end_writes();
    settings_run++;
    n = frames * clamp_dim(rows_reg, MaxRowsDef) * clamp_dim(cols_reg, MaxColsDef);
    repeat (n) queue_sample(rand_sample());
  endtask

  // Stop ten rows into a tall grid, then cut the row count below the current row
  task automatic wrap_rows_test();
    run_setting(SizeW'(2047), SizeW'(3), rand_scale(), 0);
    repeat (30) queue_sample(rand_sample());
    wait_drained();
    write_reg(CfgRows, CfgW'(5));
    end_writes();
    repeat (9) queue_sample(rand_sample());
  endtask

  // Stop in mid-row, then cut the column count below the current column
  task automatic shrink_cols_test();
    run_setting(SizeW'(8), SizeW'(20), rand_scale(), 0);
    repeat (3 * 20 + 12) queue_sample(rand_sample());
    wait_drained();
    write_reg(CfgCols, CfgW'(9));
    end_writes();
    repeat (2 * 9 + 4) queue_sample(rand_sample());
  endtask

  initial begin : stimulus
    int unsigned i;
    int unsigned phase;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    sender_idle_pct    = 27;
    receiver_stall_pct = 60;

    // Peak positive stencil sum on a 3x3 grid at the reset scale
    write_reg(CfgRows, CfgW'(3));
    write_reg(CfgCols, CfgW'(3));
    end_writes();
    for (i = 0; i < 9; i++) queue_sample(i == 4 ? SampleMin : SampleMax);
    wait_drained();

    // Ignored index, sizes below the minimum, full-scale factor: peak negative sum saturates
    write_reg(CfgNoReg, CfgW'(5));
    write_reg(CfgRows, CfgW'(0));
    write_reg(CfgCols, CfgW'(2));
    write_reg(CfgInvSpacing, '1);
    end_writes();
    for (i = 0; i < 9; i++) queue_sample(i == 4 ? SampleMax : SampleMin);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct    = 27;
          receiver_stall_pct = 60;
          wrap_rows_test();
        end
        1: begin
          sender_idle_pct    = 60;
          receiver_stall_pct = 27;
          shrink_cols_test();
        end
        default: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
      endcase
      while (items_queued < DirectedItems + (phase + 1) * RandomItems / 3)
        run_setting(SizeW'($urandom_range(0, 12)), SizeW'($urandom_range(0, 24)),
                    rand_scale(), $urandom_range(1, 2));
    end
    // A few words into the widest grid, the column size given out of range from above
    run_setting(SizeW'(3), SizeW'(2047), rand_scale(), 0);
    repeat (40) queue_sample(rand_sample());
    wait_drained();

    $display("Streamed %0d samples over %0d grid settings; checked %0d cell words",
             items_taken, settings_run, cells_checked);
    $display("(%0d saturated, %0d frame ends), %0d mismatches",
             cells_clipped, frames_done, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
